FILE: hdl/gafs_pkg.sv
// Shared definitions for the grid route engine: default sizes, direction and
// route codes, configuration register indexes and the heading reversal table.
// Depends on nothing; used by grid_astar_first_step.
package gafs_pkg;

  localparam int DEF_MAX_WIDTH   = 64;
  localparam int DEF_MAX_HEIGHT  = 64;
  localparam int DEF_QUEUE_DEPTH = 16388;

  localparam int COORD_W = 6;
  localparam int CFG_W   = 7;

  typedef logic [2:0] dir_t;
  localparam dir_t DIR_NONE  = 3'd0;
  localparam dir_t DIR_UP    = 3'd1;
  localparam dir_t DIR_DOWN  = 3'd2;
  localparam dir_t DIR_LEFT  = 3'd3;
  localparam dir_t DIR_RIGHT = 3'd4;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_AT_GOAL = 2'd0;
  localparam kind_t KIND_SEARCH  = 2'd1;
  localparam kind_t KIND_GREEDY  = 2'd2;

  typedef logic [0:0] reg_idx_t;
  localparam reg_idx_t REG_MAP_WIDTH  = 1'b0;
  localparam reg_idx_t REG_MAP_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] RESET_MAP_SIZE = 7'd64;

  function automatic dir_t reverse_dir(input dir_t heading);
    dir_t r;
    unique case (heading)
      DIR_UP:    r = DIR_DOWN;
      DIR_DOWN:  r = DIR_UP;
      DIR_LEFT:  r = DIR_RIGHT;
      DIR_RIGHT: r = DIR_LEFT;
      default:   r = DIR_NONE;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/gafs_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; instanced for the map, the cell store and the queue.
module gafs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/grid_astar_first_step.sv
// Grid route engine: stored road map, A* first-move search and greedy fallback.
// Depends on gafs_pkg and gafs_ram.
//
//   channel  | ports                          | beat meaning
//   in       | in_valid / in_ready / in_*     | map cell write or route query
//   out      | out_valid / out_ready / out_*  | first move and route kind
//   cfg      | cfg_we / cfg_index / cfg_data  | map width or height write
//
// A query with start equal to goal goes straight to the result with no move; a
// query whose goal is off the map or is a wall takes the greedy step.
// A searched query first sweeps the cell store, one cell a cycle, then pops
// queue entries through the pop, wait and node-check states and visits each
// in-map neighbor through a read and a check state, all bound by the single
// port of each memory. Reset is synchronous; it clears the control state and
// sets the map size registers to 64, and the map memory is then cleared to
// wall one cell a cycle with in_ready low. A full output register stalls
// only the final beat; inputs are taken one query at a time.
module grid_astar_first_step #(
  parameter int MAX_WIDTH   = gafs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = gafs_pkg::DEF_MAX_HEIGHT,
  parameter int QUEUE_DEPTH = gafs_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_action,
  input  logic [5:0]              in_cell_x,
  input  logic [5:0]              in_cell_y,
  input  logic                    in_road,
  input  logic [5:0]              in_from_x,
  input  logic [5:0]              in_from_y,
  input  logic [5:0]              in_to_x,
  input  logic [5:0]              in_to_y,
  input  logic [2:0]              in_heading,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2:0]              out_step_dir,
  output logic [1:0]              out_route_kind,
  input  logic                    cfg_we,
  input  gafs_pkg::reg_idx_t      cfg_index,
  input  logic [6:0]              cfg_data
);

  localparam int XW    = ($clog2(MAX_WIDTH) > gafs_pkg::COORD_W) ?
                         $clog2(MAX_WIDTH) : gafs_pkg::COORD_W;
  localparam int YW    = ($clog2(MAX_HEIGHT) > gafs_pkg::COORD_W) ?
                         $clog2(MAX_HEIGHT) : gafs_pkg::COORD_W;
  localparam int DW    = ((XW > YW) ? XW : YW) + 2;
  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = AW + 1;
  localparam int NW    = CW + 3;
  localparam int QW    = CW + XW + YW;
  localparam int QAW   = $clog2(QUEUE_DEPTH);
  localparam int QCW   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [8:0]    MAXW9    = 9'(MAX_WIDTH);
  localparam logic [8:0]    MAXH9    = 9'(MAX_HEIGHT);
  localparam logic [CW-1:0] COST_INF = '1;
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_GOAL    = 14'b00000000000010,
    S_CLEAR   = 14'b00000000000100,
    S_START   = 14'b00000000001000,
    S_NRD     = 14'b00000000010000,
    S_NCHK    = 14'b00000000100000,
    S_POP     = 14'b00000001000000,
    S_PWAIT   = 14'b00000010000000,
    S_NODECHK = 14'b00000100000000,
    S_GRD     = 14'b00001000000000,
    S_GCHK    = 14'b00010000000000,
    S_GFIN    = 14'b00100000000000,
    S_DONE    = 14'b01000000000000,
    S_INIT    = 14'b10000000000000
  } state_t;

  function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x,
                                              input logic [YW-1:0] y);
    return AW'(AW'(y) * AW'(MAX_WIDTH) + AW'(x));
  endfunction

  state_t state_r, state_nxt;
  logic [6:0] mw_r, mw_nxt, mh_r, mh_nxt;
  logic [5:0] fx_r, fx_nxt, fy_r, fy_nxt, tx_r, tx_nxt, ty_r, ty_nxt;
  gafs_pkg::dir_t rev_r, rev_nxt, dir_r, dir_nxt, mv_r, mv_nxt, best_r, best_nxt;
  gafs_pkg::dir_t res_dir_r, res_dir_nxt;
  gafs_pkg::kind_t res_kind_r, res_kind_nxt;
  logic [XW-1:0] cx_r, cx_nxt;
  logic [YW-1:0] cy_r, cy_nxt;
  logic [CW-1:0] g_r, g_nxt;
  logic seed_r, seed_nxt, inmap_r, inmap_nxt, revroad_r, revroad_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [DW-1:0] k_r, k_nxt, bestd_r, bestd_nxt;
  logic out_valid_r, out_valid_nxt;
  gafs_pkg::dir_t out_dir_r, out_dir_nxt;
  gafs_pkg::kind_t out_kind_r, out_kind_nxt;
  logic ring_r, ring_nxt;
  logic [QAW-1:0] head0_r, head0_nxt, head1_r, head1_nxt;
  logic [QAW-1:0] tail0_r, tail0_nxt, tail1_r, tail1_nxt;
  logic [QCW-1:0] cnt0_r, cnt0_nxt, cnt1_r, cnt1_nxt;

  logic [8:0] usedw, usedh;
  logic [XW:0] nx;
  logic [YW:0] ny;
  logic n_inmap, toward;
  logic [AW-1:0] n_addr;
  logic [XW:0] adx;
  logic [YW:0] ady;
  logic [DW-1:0] k;
  logic [QCW:0] q_total;
  logic [QCW-1:0] cur_cnt, oth_cnt;
  logic [CW-1:0] ng;
  logic accept;

  logic road_we, road_wdata, road_rdata;
  logic [AW-1:0] road_waddr, road_raddr;
  logic node_we;
  logic [AW-1:0] node_waddr, node_raddr;
  logic [NW-1:0] node_wdata, node_rdata;
  logic q_we;
  logic [QAW:0] q_waddr, q_raddr;
  logic [QW-1:0] q_wdata, q_rdata;

  logic [CW-1:0] node_cost;
  gafs_pkg::dir_t node_mv;
  logic [CW-1:0] q_g;
  logic [XW-1:0] q_x;
  logic [YW-1:0] q_y;

  assign node_cost = node_rdata[NW-1:3];
  assign node_mv   = node_rdata[2:0];
  assign q_g       = q_rdata[QW-1 -: CW];
  assign q_x       = q_rdata[XW+YW-1:YW];
  assign q_y       = q_rdata[YW-1:0];

  assign usedw = ({2'b0, mw_r} > MAXW9) ? MAXW9 : {2'b0, mw_r};
  assign usedh = ({2'b0, mh_r} > MAXH9) ? MAXH9 : {2'b0, mh_r};

  always_comb begin
    nx = {1'b0, cx_r};
    ny = {1'b0, cy_r};
    unique case (dir_r)
      gafs_pkg::DIR_UP:    ny = {1'b0, cy_r} - (YW+1)'(1);
      gafs_pkg::DIR_DOWN:  ny = {1'b0, cy_r} + (YW+1)'(1);
      gafs_pkg::DIR_LEFT:  nx = {1'b0, cx_r} - (XW+1)'(1);
      gafs_pkg::DIR_RIGHT: nx = {1'b0, cx_r} + (XW+1)'(1);
      default: ;
    endcase
  end

  always_comb begin
    unique case (dir_r)
      gafs_pkg::DIR_UP:    toward = YW'(ty_r) < cy_r;
      gafs_pkg::DIR_DOWN:  toward = YW'(ty_r) > cy_r;
      gafs_pkg::DIR_LEFT:  toward = XW'(tx_r) < cx_r;
      gafs_pkg::DIR_RIGHT: toward = XW'(tx_r) > cx_r;
      default:             toward = 1'b0;
    endcase
  end

  assign n_inmap = (9'(nx) < usedw) && (9'(ny) < usedh);
  assign n_addr  = cell_addr(nx[XW-1:0], ny[YW-1:0]);
  assign adx = (nx > (XW+1)'(tx_r)) ? nx - (XW+1)'(tx_r) : (XW+1)'(tx_r) - nx;
  assign ady = (ny > (YW+1)'(ty_r)) ? ny - (YW+1)'(ty_r) : (YW+1)'(ty_r) - ny;
  assign k   = DW'(adx) + DW'(ady);

  assign q_total = (QCW+1)'(cnt0_r) + (QCW+1)'(cnt1_r);
  assign cur_cnt = ring_r ? cnt1_r : cnt0_r;
  assign oth_cnt = ring_r ? cnt0_r : cnt1_r;
  assign ng      = g_r + CW'(1);

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (state_r == S_INIT) begin
      road_we    = 1'b1;
      road_waddr = clr_r;
      road_wdata = 1'b0;
    end else begin
      road_we    = accept && !in_action && (9'(in_cell_x) < MAXW9) &&
                   (9'(in_cell_y) < MAXH9);
      road_waddr = cell_addr(XW'(in_cell_x), YW'(in_cell_y));
      road_wdata = in_road;
    end
    road_raddr = (state_r == S_IDLE) ? cell_addr(XW'(in_to_x), YW'(in_to_y)) : n_addr;
  end

  always_comb begin
    node_we    = 1'b0;
    node_waddr = n_addr;
    node_wdata = {ng, (seed_r ? dir_r : mv_r)};
    node_raddr = (state_r == S_PWAIT) ? cell_addr(q_x, q_y) : n_addr;
    q_we       = 1'b0;
    q_waddr    = (toward ^ ring_r) ? {1'b0, tail0_r} : {1'b1, tail1_r};
    q_wdata    = {ng, nx[XW-1:0], ny[YW-1:0]};
    q_raddr    = ring_r ? {1'b1, head1_r} : {1'b0, head0_r};
    if (state_r == S_CLEAR) begin
      node_we    = 1'b1;
      node_waddr = clr_r;
      node_wdata = {COST_INF, gafs_pkg::DIR_NONE};
    end else if (state_r == S_START) begin
      node_we    = (9'(fx_r) < usedw) && (9'(fy_r) < usedh);
      node_waddr = cell_addr(XW'(fx_r), YW'(fy_r));
      node_wdata = {CW'(0), gafs_pkg::DIR_NONE};
    end else if (state_r == S_NCHK) begin
      node_we = road_rdata && (ng < node_cost);
      q_we    = node_we && (q_total < (QCW+1)'(QUEUE_DEPTH));
    end
  end

  // The push ring is the current ring when the move nears the goal, since f
  // then stays the same; otherwise f grows by two and the entry waits.
  always_comb begin
    state_nxt    = state_r;
    mw_nxt       = mw_r;
    mh_nxt       = mh_r;
    fx_nxt       = fx_r;
    fy_nxt       = fy_r;
    tx_nxt       = tx_r;
    ty_nxt       = ty_r;
    rev_nxt      = rev_r;
    dir_nxt      = dir_r;
    mv_nxt       = mv_r;
    best_nxt     = best_r;
    res_dir_nxt  = res_dir_r;
    res_kind_nxt = res_kind_r;
    cx_nxt       = cx_r;
    cy_nxt       = cy_r;
    g_nxt        = g_r;
    seed_nxt     = seed_r;
    inmap_nxt    = inmap_r;
    revroad_nxt  = revroad_r;
    clr_nxt      = clr_r;
    k_nxt        = k_r;
    bestd_nxt    = bestd_r;
    out_valid_nxt = out_valid_r;
    out_dir_nxt  = out_dir_r;
    out_kind_nxt = out_kind_r;
    ring_nxt     = ring_r;
    head0_nxt    = head0_r;
    head1_nxt    = head1_r;
    tail0_nxt    = tail0_r;
    tail1_nxt    = tail1_r;
    cnt0_nxt     = cnt0_r;
    cnt1_nxt     = cnt1_r;

    if (cfg_we) begin
      unique case (cfg_index)
        gafs_pkg::REG_MAP_WIDTH:  mw_nxt = cfg_data;
        gafs_pkg::REG_MAP_HEIGHT: mh_nxt = cfg_data;
        default: ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (q_we) begin
      if (q_waddr[QAW]) begin
        tail1_nxt = tail1_r + QAW'(1);
        cnt1_nxt  = cnt1_r + QCW'(1);
      end else begin
        tail0_nxt = tail0_r + QAW'(1);
        cnt0_nxt  = cnt0_r + QCW'(1);
      end
    end

    unique case (state_r)
      S_INIT: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == LAST_CELL) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept && in_action) begin
          fx_nxt    = in_from_x;
          fy_nxt    = in_from_y;
          tx_nxt    = in_to_x;
          ty_nxt    = in_to_y;
          rev_nxt   = gafs_pkg::reverse_dir(in_heading);
          ring_nxt  = 1'b0;
          head0_nxt = '0;
          head1_nxt = '0;
          tail0_nxt = '0;
          tail1_nxt = '0;
          cnt0_nxt  = '0;
          cnt1_nxt  = '0;
          if ((in_from_x == in_to_x) && (in_from_y == in_to_y)) begin
            res_dir_nxt  = gafs_pkg::DIR_NONE;
            res_kind_nxt = gafs_pkg::KIND_AT_GOAL;
            state_nxt    = S_DONE;
          end else if ((9'(in_to_x) < usedw) && (9'(in_to_y) < usedh)) begin
            state_nxt = S_GOAL;
          end else begin
            cx_nxt      = XW'(in_from_x);
            cy_nxt      = YW'(in_from_y);
            dir_nxt     = gafs_pkg::DIR_UP;
            best_nxt    = gafs_pkg::DIR_NONE;
            bestd_nxt   = '1;
            revroad_nxt = 1'b0;
            state_nxt   = S_GRD;
          end
        end
      end
      S_GOAL: begin
        clr_nxt = '0;
        if (road_rdata) begin
          state_nxt = S_CLEAR;
        end else begin
          cx_nxt      = XW'(fx_r);
          cy_nxt      = YW'(fy_r);
          dir_nxt     = gafs_pkg::DIR_UP;
          best_nxt    = gafs_pkg::DIR_NONE;
          bestd_nxt   = '1;
          revroad_nxt = 1'b0;
          state_nxt   = S_GRD;
        end
      end
      S_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == LAST_CELL) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        cx_nxt    = XW'(fx_r);
        cy_nxt    = YW'(fy_r);
        g_nxt     = '0;
        seed_nxt  = 1'b1;
        dir_nxt   = gafs_pkg::DIR_UP;
        state_nxt = S_NRD;
      end
      S_NRD: begin
        if ((seed_r && (dir_r == rev_r)) || !n_inmap) begin
          if (dir_r == gafs_pkg::DIR_RIGHT) begin
            state_nxt = S_POP;
          end else begin
            dir_nxt = dir_r + 3'd1;
          end
        end else begin
          state_nxt = S_NCHK;
        end
      end
      S_NCHK: begin
        if (dir_r == gafs_pkg::DIR_RIGHT) begin
          state_nxt = S_POP;
        end else begin
          dir_nxt   = dir_r + 3'd1;
          state_nxt = S_NRD;
        end
      end
      S_POP: begin
        if (cur_cnt == '0) begin
          if (oth_cnt == '0) begin
            cx_nxt      = XW'(fx_r);
            cy_nxt      = YW'(fy_r);
            dir_nxt     = gafs_pkg::DIR_UP;
            best_nxt    = gafs_pkg::DIR_NONE;
            bestd_nxt   = '1;
            revroad_nxt = 1'b0;
            state_nxt   = S_GRD;
          end else begin
            ring_nxt = !ring_r;
          end
        end else begin
          if (ring_r) begin
            head1_nxt = head1_r + QAW'(1);
            cnt1_nxt  = cnt1_r - QCW'(1);
          end else begin
            head0_nxt = head0_r + QAW'(1);
            cnt0_nxt  = cnt0_r - QCW'(1);
          end
          state_nxt = S_PWAIT;
        end
      end
      S_PWAIT: begin
        cx_nxt    = q_x;
        cy_nxt    = q_y;
        g_nxt     = q_g;
        state_nxt = S_NODECHK;
      end
      S_NODECHK: begin
        if ((cx_r == XW'(tx_r)) && (cy_r == YW'(ty_r))) begin
          res_dir_nxt  = node_mv;
          res_kind_nxt = gafs_pkg::KIND_SEARCH;
          state_nxt    = S_DONE;
        end else if (g_r > node_cost) begin
          state_nxt = S_POP;
        end else begin
          mv_nxt    = node_mv;
          seed_nxt  = 1'b0;
          dir_nxt   = gafs_pkg::DIR_UP;
          state_nxt = S_NRD;
        end
      end
      S_GRD: begin
        inmap_nxt = n_inmap;
        k_nxt     = k;
        state_nxt = S_GCHK;
      end
      S_GCHK: begin
        if (dir_r == rev_r) begin
          revroad_nxt = inmap_r && road_rdata;
        end else if (inmap_r && road_rdata && (k_r < bestd_r)) begin
          best_nxt  = dir_r;
          bestd_nxt = k_r;
        end
        if (dir_r == gafs_pkg::DIR_RIGHT) begin
          state_nxt = S_GFIN;
        end else begin
          dir_nxt   = dir_r + 3'd1;
          state_nxt = S_GRD;
        end
      end
      S_GFIN: begin
        if (best_r != gafs_pkg::DIR_NONE) begin
          res_dir_nxt = best_r;
        end else if ((rev_r != gafs_pkg::DIR_NONE) && revroad_r) begin
          res_dir_nxt = rev_r;
        end else begin
          res_dir_nxt = gafs_pkg::DIR_NONE;
        end
        res_kind_nxt = gafs_pkg::KIND_GREEDY;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_dir_nxt   = res_dir_r;
          out_kind_nxt  = res_kind_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_r       <= '0;
      mw_r        <= gafs_pkg::RESET_MAP_SIZE;
      mh_r        <= gafs_pkg::RESET_MAP_SIZE;
      out_valid_r <= 1'b0;
      ring_r      <= 1'b0;
      head0_r     <= '0;
      head1_r     <= '0;
      tail0_r     <= '0;
      tail1_r     <= '0;
      cnt0_r      <= '0;
      cnt1_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      mw_r        <= mw_nxt;
      mh_r        <= mh_nxt;
      out_valid_r <= out_valid_nxt;
      ring_r      <= ring_nxt;
      head0_r     <= head0_nxt;
      head1_r     <= head1_nxt;
      tail0_r     <= tail0_nxt;
      tail1_r     <= tail1_nxt;
      cnt0_r      <= cnt0_nxt;
      cnt1_r      <= cnt1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fx_r       <= fx_nxt;
    fy_r       <= fy_nxt;
    tx_r       <= tx_nxt;
    ty_r       <= ty_nxt;
    rev_r      <= rev_nxt;
    dir_r      <= dir_nxt;
    mv_r       <= mv_nxt;
    best_r     <= best_nxt;
    res_dir_r  <= res_dir_nxt;
    res_kind_r <= res_kind_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    g_r        <= g_nxt;
    seed_r     <= seed_nxt;
    inmap_r    <= inmap_nxt;
    revroad_r  <= revroad_nxt;
    k_r        <= k_nxt;
    bestd_r    <= bestd_nxt;
    out_dir_r  <= out_dir_nxt;
    out_kind_r <= out_kind_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_step_dir   = out_dir_r;
  assign out_route_kind = out_kind_r;

  gafs_ram #(.WIDTH(1), .DEPTH(CELLS)) u_road_ram (
    .clk   (clk),
    .we    (road_we),
    .waddr (road_waddr),
    .wdata (road_wdata),
    .raddr (road_raddr),
    .rdata (road_rdata)
  );

  gafs_ram #(.WIDTH(NW), .DEPTH(CELLS)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  gafs_ram #(.WIDTH(QW), .DEPTH(2 ** (QAW + 1))) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_total <= (QCW+1)'(QUEUE_DEPTH))
    else $error("open queue holds more entries than its depth");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state is not one-hot");

  a_search_moves: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == gafs_pkg::KIND_SEARCH) |->
      (out_dir_r != gafs_pkg::DIR_NONE))
    else $error("search result without a move");

  a_goal_still: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == gafs_pkg::KIND_AT_GOAL) |->
      (out_dir_r == gafs_pkg::DIR_NONE))
    else $error("at-goal result with a move");

  a_pop_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) && (cur_cnt != '0) |=> (state_r == S_PWAIT))
    else $error("pop from a non-empty ring did not read the queue");

endmodule
